// ===== design/lsb_pkg.sv =====
// Package for the linear seam blend: field widths, blend mode codes and the
// structs passed between the front, lane and merge stages. No dependencies.
`timescale 1ns / 1ps

package lsb_pkg;

	localparam int CHAN_W = 8;               // one color channel
	localparam int COL_W  = 12;              // column index
	localparam int WID_W  = 13;              // image width and overlap width
	localparam int NUM_W  = WID_W + CHAN_W;  // weighted sum, below 256 * W
	localparam int NLANE  = 3;               // red, green, blue
	localparam int NDIV   = CHAN_W;          // one quotient bit per divide stage

	typedef logic [CHAN_W-1:0] chan_t;

	// What the merge stage sends out for an item
	typedef enum logic [1:0] {
		MODE_OVERLAY = 2'b00,
		MODE_BASE    = 2'b01,
		MODE_BLEND   = 2'b10
	} mode_t;

	// Decoded item leaving the front stage
	typedef struct packed {
		mode_t                   mode;
		logic [COL_W-1:0]        k;      // column - overlap_start
		logic [WID_W-1:0]        wmk;    // width - column
		chan_t [NLANE-1:0]       base;
		chan_t [NLANE-1:0]       over;
	} front_t;

	// One lane's result at the end of its divider
	typedef struct packed {
		chan_t quo;
		chan_t base;
		chan_t over;
	} lane_out_t;

endpackage

// ===== design/linear_seam_blend.sv =====
// Top level of the linear seam blend: config registers, stage valids and
// stall chain, front, three color lanes and merge. Depends on lsb_pkg,
// lsb_front, lsb_lane and lsb_merge.
//
//   channel  | dir | handshake                      | payload
//   ---------+-----+--------------------------------+---------------------------------
//   s_*      | in  | s_tvalid / s_tready            | column, base RGB, overlay RGB
//   m_*      | out | m_tvalid / m_tready            | blended RGB
//   apb      | in  | psel, penable, pwrite, pready  | overlap_start (0x0), image_width (0x4)
//
// One item per cycle sustained while m_tready is high; stages: front stage, multiply stage,
// eight restoring divide stages (one quotient bit each, per color lane), output register.
// Reset clears the stage valids and loads overlap_start = 0, image_width = 4096.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up; s_tready drops only when every stage holds an item and m_tready is low.
`timescale 1ns / 1ps

module linear_seam_blend #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// column[11:0], base_red[19:12], base_green[27:20], base_blue[35:28],
	// overlay_red[43:36], overlay_green[51:44], overlay_blue[59:52], zero[63:60]
	input  logic [63:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// blend_red[7:0], blend_green[15:8], blend_blue[23:16]
	output logic [23:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NDIV   = lsb_pkg::NDIV;
	localparam int NLANE  = lsb_pkg::NLANE;
	localparam int CHAN_W = lsb_pkg::CHAN_W;
	localparam int WID_W  = lsb_pkg::WID_W;
	localparam int COL_W  = lsb_pkg::COL_W;
	localparam int NSTG   = NDIV + 3;     // front, multiply, divide stages, output
	localparam int OUT_ST = NSTG - 1;
	localparam int DIV_ST = NSTG - 2;     // last divide stage

	localparam logic REG_OVERLAP = 1'b0;
	localparam logic REG_WIDTH   = 1'b1;

	logic [COL_W-1:0] overlap_start_q;
	logic [WID_W-1:0] image_width_q;
	logic [WID_W-1:0] width_c;
	logic [WID_W-1:0] w_q;
	logic             cfg_wr;

	logic [NSTG-1:0]  v_q;
	logic [NSTG-1:0]  en;

	lsb_pkg::chan_t [NLANE-1:0]     base_in;
	lsb_pkg::chan_t [NLANE-1:0]     over_in;
	lsb_pkg::front_t                fr_s1;
	lsb_pkg::mode_t                 mode_s [1:DIV_ST];
	lsb_pkg::lane_out_t [NLANE-1:0] lane_q;
	lsb_pkg::chan_t [NLANE-1:0]     blend_q;

	// Config port: write in the access phase, read back by word index
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_start_q <= '0;
			image_width_q   <= WID_W'(4096);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_OVERLAP: overlap_start_q <= pwdata[COL_W-1:0];
				REG_WIDTH:   image_width_q   <= pwdata[WID_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_OVERLAP: prdata = {{(32 - COL_W){1'b0}}, overlap_start_q};
			REG_WIDTH:   prdata = {{(32 - WID_W){1'b0}}, image_width_q};
			default:     prdata = '0;
		endcase
	end

	// Clip the width, and keep the overlap width registered for the dividers
	always_comb begin
		width_c = image_width_q;
		if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			width_c = MAX_WIDTH[WID_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else begin
			w_q <= width_c - {1'b0, overlap_start_q};
		end
	end

	// Stall chain: a stage loads when empty or when its successor loads
	always_comb begin
		en[OUT_ST] = !v_q[OUT_ST] || m_tready;
		for (int i = OUT_ST - 1; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[OUT_ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// Unpack the input item
	for (genvar c = 0; c < NLANE; c++) begin : g_unpack
		assign base_in[c] = s_tdata[COL_W + CHAN_W*c +: CHAN_W];
		assign over_in[c] = s_tdata[COL_W + CHAN_W*(NLANE + c) +: CHAN_W];
	end

	lsb_front u_front (
		.clk           (clk),
		.en            (en[0]),
		.column        (s_tdata[COL_W-1:0]),
		.base          (base_in),
		.over          (over_in),
		.width         (width_c),
		.overlap_start (overlap_start_q),
		.fr_s1         (fr_s1)
	);

	// Carry the mode alongside the lanes
	always_ff @(posedge clk) begin
		if (en[1]) begin
			mode_s[1] <= fr_s1.mode;
		end
		for (int i = 2; i <= DIV_ST; i++) begin
			if (en[i]) begin
				mode_s[i] <= mode_s[i-1];
			end
		end
	end

	for (genvar c = 0; c < NLANE; c++) begin : g_lane
		lsb_lane u_lane (
			.clk      (clk),
			.en       (en[DIV_ST:1]),
			.w        (w_q),
			.base     (fr_s1.base[c]),
			.over     (fr_s1.over[c]),
			.k        (fr_s1.k),
			.wmk      (fr_s1.wmk),
			.lane_out (lane_q[c])
		);
	end

	lsb_merge u_merge (
		.clk     (clk),
		.en      (en[OUT_ST]),
		.mode    (mode_s[DIV_ST]),
		.lanes   (lane_q),
		.blend_q (blend_q)
	);

	assign m_tdata = blend_q;

	// The blended red channel lies between its base and overlay values
	a_blend_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[DIV_ST] && (mode_s[DIV_ST] == lsb_pkg::MODE_BLEND) |->
		((lane_q[0].quo <= lane_q[0].base) || (lane_q[0].quo <= lane_q[0].over)) &&
		((lane_q[0].quo >= lane_q[0].base) || (lane_q[0].quo >= lane_q[0].over)))
		else $error("blended red channel outside base/overlay range");

	// A blend item never sees an empty overlap
	a_blend_width: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] && (fr_s1.mode == lsb_pkg::MODE_BLEND) |-> (w_q != '0))
		else $error("blend item with zero overlap width");

	// Input side stalls only when the whole pipeline is full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&v_q) && !m_tready)
		else $error("input stalled with a free stage");

	// A result that is not taken stays in the output stage
	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> v_q[OUT_ST])
		else $error("output item dropped while stalled");

endmodule

// ===== design/lsb_front.sv =====
// Front stage of the seam blend: classifies each pixel against the overlap
// and forms the two blend weights. Depends on lsb_pkg.
`timescale 1ns / 1ps

module lsb_front (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [lsb_pkg::COL_W-1:0]              column,
	input  lsb_pkg::chan_t [lsb_pkg::NLANE-1:0]    base,
	input  lsb_pkg::chan_t [lsb_pkg::NLANE-1:0]    over,
	input  logic [lsb_pkg::WID_W-1:0]              width,
	input  logic [lsb_pkg::COL_W-1:0]              overlap_start,
	output lsb_pkg::front_t                        fr_s1
);

	logic [lsb_pkg::WID_W-1:0] col_x;
	lsb_pkg::front_t           fr_d;

	assign col_x = {1'b0, column};

	// Classify the pixel: beyond the base image, left of overlap or black overlay, blend
	always_comb begin
		fr_d.base = base;
		fr_d.over = over;
		fr_d.k    = column - overlap_start;
		fr_d.wmk  = width - col_x;
		if (col_x >= width) begin
			fr_d.mode = lsb_pkg::MODE_OVERLAY;
		end else if ((column < overlap_start) || (over == '0)) begin
			fr_d.mode = lsb_pkg::MODE_BASE;
		end else begin
			fr_d.mode = lsb_pkg::MODE_BLEND;
		end
	end

	// Hold the decoded item while the next stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			fr_s1 <= fr_d;
		end
	end

endmodule

// ===== design/lsb_lane.sv =====
// One color lane of the seam blend: weighted sum of base and overlay, then an
// eight-stage restoring divider by the overlap width. Depends on lsb_pkg.
`timescale 1ns / 1ps

module lsb_lane (
	input  logic                          clk,
	input  logic [lsb_pkg::NDIV:0]        en,     // [0] multiply, [i+1] divide stage i
	input  logic [lsb_pkg::WID_W-1:0]     w,
	input  lsb_pkg::chan_t                base,
	input  lsb_pkg::chan_t                over,
	input  logic [lsb_pkg::COL_W-1:0]     k,
	input  logic [lsb_pkg::WID_W-1:0]     wmk,
	output lsb_pkg::lane_out_t            lane_out
);

	localparam int NUM_W  = lsb_pkg::NUM_W;
	localparam int NDIV   = lsb_pkg::NDIV;
	localparam int CHAN_W = lsb_pkg::CHAN_W;

	logic [NUM_W-1:0]  p_base;
	logic [NUM_W-1:0]  p_over;
	logic [NUM_W-1:0]  n_s2;
	lsb_pkg::chan_t    base_s2;
	lsb_pkg::chan_t    over_s2;

	logic [NUM_W-1:0]  rem_s  [NDIV];
	logic [CHAN_W-1:0] quo_s  [NDIV];
	lsb_pkg::chan_t    base_s [NDIV];
	lsb_pkg::chan_t    over_s [NDIV];

	// Weighted sum base*(W-k) + overlay*k, bounded by 255*W
	assign p_base = {{lsb_pkg::WID_W{1'b0}}, base} * {{CHAN_W{1'b0}}, wmk};
	assign p_over = {{lsb_pkg::WID_W{1'b0}}, over} *
	                {{(NUM_W - lsb_pkg::COL_W){1'b0}}, k};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s2    <= p_base + p_over;
			base_s2 <= base;
			over_s2 <= over;
		end
	end

	// Restoring divide, most significant quotient bit first
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		logic [NUM_W-1:0]  rem_in;
		logic [NUM_W-1:0]  dvs;
		logic [CHAN_W-1:0] q_in;
		lsb_pkg::chan_t    b_in;
		lsb_pkg::chan_t    o_in;
		logic              ge;

		if (i == 0) begin : g_first
			assign rem_in = n_s2;
			assign q_in   = '0;
			assign b_in   = base_s2;
			assign o_in   = over_s2;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign q_in   = quo_s[i-1];
			assign b_in   = base_s[i-1];
			assign o_in   = over_s[i-1];
		end

		assign dvs = {{CHAN_W{1'b0}}, w} << (NDIV - 1 - i);
		assign ge  = (rem_in >= dvs);

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				rem_s[i]  <= ge ? (rem_in - dvs) : rem_in;
				quo_s[i]  <= {q_in[CHAN_W-2:0], ge};
				base_s[i] <= b_in;
				over_s[i] <= o_in;
			end
		end
	end

	assign lane_out.quo  = quo_s[NDIV-1];
	assign lane_out.base = base_s[NDIV-1];
	assign lane_out.over = over_s[NDIV-1];

endmodule

// ===== design/lsb_merge.sv =====
// Merge stage of the seam blend: picks overlay, base or blended value for each
// lane and holds the output register. Depends on lsb_pkg.
`timescale 1ns / 1ps

module lsb_merge (
	input  logic                                      clk,
	input  logic                                      en,
	input  lsb_pkg::mode_t                            mode,
	input  lsb_pkg::lane_out_t [lsb_pkg::NLANE-1:0]   lanes,
	output lsb_pkg::chan_t [lsb_pkg::NLANE-1:0]       blend_q
);

	lsb_pkg::chan_t [lsb_pkg::NLANE-1:0] blend_d;

	// Select the result per lane by the item's mode
	always_comb begin
		for (int c = 0; c < lsb_pkg::NLANE; c++) begin
			case (mode)
				lsb_pkg::MODE_OVERLAY: blend_d[c] = lanes[c].over;
				lsb_pkg::MODE_BASE:    blend_d[c] = lanes[c].base;
				lsb_pkg::MODE_BLEND:   blend_d[c] = lanes[c].quo;
				default:               blend_d[c] = lanes[c].base;
			endcase
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (en) begin
			blend_q <= blend_d;
		end
	end

endmodule
